@@ rtl/core/bcs_pkg.sv @@
// Bezier curve sampler: shared types, register codes and fixed-point helpers.
package bcs_pkg;

	localparam int WFRAC      = 30;
	localparam int NPOINTS    = 6;
	localparam int STEP_RESET = 16777;

	typedef logic [WFRAC:0]     unit_t;
	typedef logic [2*WFRAC+1:0] wide_t;
	typedef logic [3:0]         reg_idx_t;
	typedef logic [3:0]         binom_t;

	localparam unit_t UNIT_ONE = unit_t'(1) << WFRAC;

	localparam reg_idx_t REG_DEGREE  = 4'd0;
	localparam reg_idx_t REG_STEP    = 4'd1;
	localparam reg_idx_t REG_POINT_0 = 4'd2;
	localparam reg_idx_t REG_POINT_1 = 4'd3;
	localparam reg_idx_t REG_POINT_2 = 4'd4;
	localparam reg_idx_t REG_POINT_3 = 4'd5;
	localparam reg_idx_t REG_POINT_4 = 4'd6;
	localparam reg_idx_t REG_POINT_5 = 4'd7;

	// powers of t and (1 - t), Q1.30; index 1 holds t and 1 - t themselves
	typedef struct packed {
		logic            past;
		unit_t [5:1]     tp;
		unit_t [5:1]     up;
	} pow_t;

	// product of two Q1.30 values, rounded half up
	function automatic unit_t rnd_mul(unit_t a, unit_t b);
		wide_t p;
		p = wide_t'(a) * wide_t'(b) + (wide_t'(1) << (WFRAC - 1));
		return unit_t'(p >> WFRAC);
	endfunction

	function automatic binom_t binom(logic quintic, int unsigned i);
		binom_t c;
		unique case (i)
			0:       c = 4'd1;
			1:       c = quintic ? 4'd5 : 4'd3;
			2:       c = quintic ? 4'd10 : 4'd3;
			3:       c = quintic ? 4'd10 : 4'd1;
			4:       c = quintic ? 4'd5 : 4'd0;
			5:       c = quintic ? 4'd1 : 4'd0;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/bcs_param.sv @@
// Bezier curve sampler: curve parameter t = index * step, range check, 1 - t.
module bcs_param #(
	parameter int INDEX_WIDTH     = 16,
	parameter int PARAM_FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [INDEX_WIDTH-1:0]     sample_index,
	input  logic [PARAM_FRAC_BITS:0]   step_size,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bcs_pkg::pow_t              out_item
);

	localparam int T_W = INDEX_WIDTH + PARAM_FRAC_BITS + 1;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << PARAM_FRAC_BITS;

	logic            v_s1, v_s2;
	logic            en_s1, en_s2;
	logic [T_W-1:0]  t_s1;
	bcs_pkg::pow_t   item_s2;
	bcs_pkg::pow_t   item_d;
	bcs_pkg::unit_t  t30_d;

	assign en_s2    = !v_s2 || !out_stall;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_comb begin
		t30_d          = bcs_pkg::unit_t'(t_s1[PARAM_FRAC_BITS:0]) <<
		                 (bcs_pkg::WFRAC - PARAM_FRAC_BITS);
		item_d         = '0;
		item_d.past    = t_s1 > T_ONE;
		item_d.tp[1]   = t30_d;
		item_d.up[1]   = bcs_pkg::UNIT_ONE - t30_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) t_s1 <= T_W'(sample_index) * T_W'(step_size);
		if (en_s2) item_s2 <= item_d;
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

@@ rtl/core/bcs_power.sv @@
// Bezier curve sampler: powers two to five of t and 1 - t, one per stage.
module bcs_power (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bcs_pkg::pow_t  in_item,
	output logic           out_valid,
	input  logic           out_stall,
	output bcs_pkg::pow_t  out_item
);

	logic           v_s3, v_s4, v_s5, v_s6;
	logic           en_s3, en_s4, en_s5, en_s6;
	bcs_pkg::pow_t  item_s3, item_s4, item_s5, item_s6;

	function automatic bcs_pkg::pow_t advance(bcs_pkg::pow_t p, int j);
		bcs_pkg::pow_t q;
		q       = p;
		q.tp[j] = bcs_pkg::rnd_mul(p.tp[j-1], p.tp[1]);
		q.up[j] = bcs_pkg::rnd_mul(p.up[j-1], p.up[1]);
		return q;
	endfunction

	assign en_s6    = !v_s6 || !out_stall;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_stall = !en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) item_s3 <= advance(in_item, 2);
		if (en_s4) item_s4 <= advance(item_s3, 3);
		if (en_s5) item_s5 <= advance(item_s4, 4);
		if (en_s6) item_s6 <= advance(item_s5, 5);
	end

	assign out_valid = v_s6;
	assign out_item  = item_s6;

`ifndef NO_ASSERTIONS
	a_pow_in_unit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !item_s6.past |->
			item_s6.tp[5] <= bcs_pkg::UNIT_ONE && item_s6.up[5] <= bcs_pkg::UNIT_ONE)
		else $error("power of t or 1-t above one");
`endif

endmodule

@@ rtl/core/bcs_blend.sv @@
// Bezier curve sampler: Bernstein weights, weighted point sum, rounding and saturation.
module bcs_blend #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bcs_pkg::pow_t                 in_item,
	input  logic                          quintic,
	input  logic signed [COORD_WIDTH-1:0] px [bcs_pkg::NPOINTS],
	input  logic signed [COORD_WIDTH-1:0] py [bcs_pkg::NPOINTS],
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] coord_x,
	output logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          past_end
);

	localparam int NP     = bcs_pkg::NPOINTS;
	localparam int NPAIR  = NP / 2;
	localparam int PROD_W = COORD_WIDTH + bcs_pkg::WFRAC + 1;
	localparam int ACC_W  = PROD_W + 6;
	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (bcs_pkg::WFRAC - 1);
	localparam logic signed [ACC_W-1:0] C_MAX = (ACC_W'(1) << (COORD_WIDTH - 1)) - 1;
	localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - 1;

	logic v_s7, v_s8, v_s9, v_s10, v_s11;
	logic en_s7, en_s8, en_s9, en_s10, en_s11;

	logic                               past_s7, past_s8, past_s9, past_s10, past_end_s11;
	bcs_pkg::unit_t [NP-1:0]            r_s7;
	bcs_pkg::unit_t [NP-1:0]            r_d;
	logic signed [PROD_W-1:0]           prod_x_s8 [NP];
	logic signed [PROD_W-1:0]           prod_y_s8 [NP];
	logic signed [ACC_W-1:0]            sum_x_s9 [NPAIR];
	logic signed [ACC_W-1:0]            sum_y_s9 [NPAIR];
	logic signed [ACC_W-1:0]            sum_x_d [NPAIR];
	logic signed [ACC_W-1:0]            sum_y_d [NPAIR];
	logic signed [ACC_W-1:0]            acc_x_s10, acc_y_s10;
	logic signed [COORD_WIDTH-1:0]      coord_x_s11, coord_y_s11;

	function automatic logic signed [ACC_W-1:0] scale(logic signed [PROD_W-1:0] p,
	                                                  bcs_pkg::binom_t c);
		return ACC_W'(p) * ACC_W'($signed({1'b0, c}));
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] finish(logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] s;
		logic signed [ACC_W-1:0] q;
		logic signed [COORD_WIDTH-1:0] r;
		s = a + HALF;
		q = s >>> bcs_pkg::WFRAC;
		priority if (q > C_MAX) r = COORD_WIDTH'(C_MAX);
		else if (q < C_MIN)     r = COORD_WIDTH'(C_MIN);
		else                    r = COORD_WIDTH'(q);
		return r;
	endfunction

	assign en_s11   = !v_s11 || !out_stall;
	assign en_s10   = !v_s10 || en_s11;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign in_stall = !en_s7;

	// weight i = rnd(T[i] * U[n-i]); weight 0 and the quintic weight 5 need no multiply
	always_comb begin
		r_d[0] = quintic ? in_item.up[5] : in_item.up[3];
		r_d[1] = bcs_pkg::rnd_mul(in_item.tp[1], quintic ? in_item.up[4] : in_item.up[2]);
		r_d[2] = bcs_pkg::rnd_mul(in_item.tp[2], quintic ? in_item.up[3] : in_item.up[1]);
		r_d[3] = bcs_pkg::rnd_mul(in_item.tp[3],
		                          quintic ? in_item.up[2] : bcs_pkg::UNIT_ONE);
		r_d[4] = quintic ? bcs_pkg::rnd_mul(in_item.tp[4], in_item.up[1]) : '0;
		r_d[5] = quintic ? in_item.tp[5] : '0;
	end

	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			sum_x_d[k] = scale(prod_x_s8[2*k],   bcs_pkg::binom(quintic, 2*k)) +
			             scale(prod_x_s8[2*k+1], bcs_pkg::binom(quintic, 2*k+1));
			sum_y_d[k] = scale(prod_y_s8[2*k],   bcs_pkg::binom(quintic, 2*k)) +
			             scale(prod_y_s8[2*k+1], bcs_pkg::binom(quintic, 2*k+1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= in_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			past_s7 <= in_item.past;
			r_s7    <= r_d;
		end
		if (en_s8) begin
			past_s8 <= past_s7;
			for (int i = 0; i < NP; i++) begin
				prod_x_s8[i] <= PROD_W'(px[i]) * PROD_W'($signed({1'b0, r_s7[i]}));
				prod_y_s8[i] <= PROD_W'(py[i]) * PROD_W'($signed({1'b0, r_s7[i]}));
			end
		end
		if (en_s9) begin
			past_s9 <= past_s8;
			for (int k = 0; k < NPAIR; k++) begin
				sum_x_s9[k] <= sum_x_d[k];
				sum_y_s9[k] <= sum_y_d[k];
			end
		end
		if (en_s10) begin
			past_s10  <= past_s9;
			acc_x_s10 <= sum_x_s9[0] + sum_x_s9[1] + sum_x_s9[2];
			acc_y_s10 <= sum_y_s9[0] + sum_y_s9[1] + sum_y_s9[2];
		end
		if (en_s11) begin
			past_end_s11 <= past_s10;
			coord_x_s11  <= past_s10 ? '0 : finish(acc_x_s10);
			coord_y_s11  <= past_s10 ? '0 : finish(acc_y_s10);
		end
	end

	assign out_valid = v_s11;
	assign coord_x   = coord_x_s11;
	assign coord_y   = coord_y_s11;
	assign past_end  = past_end_s11;

`ifndef NO_ASSERTIONS
	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 && past_end_s11 |-> coord_x_s11 == '0 && coord_y_s11 == '0)
		else $error("past-end word carries a nonzero point");
	a_cubic_tail: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !quintic |-> r_s7[4] == '0 && r_s7[5] == '0)
		else $error("cubic curve has weight on points four or five");
`endif

endmodule

@@ rtl/core/bezier_curve_sampler.sv @@
// Bezier curve sampler top level: configuration registers and the eleven-stage pipeline.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   sample_index
//   out      output     out_valid / out_stall coord_x, coord_y, past_end
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One word per clock sustained while out_stall is low; each result is registered through every stage in order.
// Depth is set by the chain of power multiplies (t^2 .. t^5), one per stage.
// Reset clears all valid bits and loads the configuration reset values.
// A stall holds only the stages behind a full stage; empty stages keep filling.
module bezier_curve_sampler #(
	parameter int COORD_WIDTH     = 32,
	parameter int PARAM_FRAC_BITS = 24,
	parameter int INDEX_WIDTH     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [INDEX_WIDTH-1:0]        sample_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] coord_x,
	output logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          past_end,
	input  logic                          cfg_we,
	input  bcs_pkg::reg_idx_t             cfg_index,
	input  logic [63:0]                   cfg_data
);

	localparam int NP     = bcs_pkg::NPOINTS;
	localparam int STEP_W = PARAM_FRAC_BITS + 1;

	logic                          degree_q;
	logic [STEP_W-1:0]             step_q;
	logic signed [COORD_WIDTH-1:0] px_q [NP];
	logic signed [COORD_WIDTH-1:0] py_q [NP];
	logic [2:0]                    pidx;

	logic           par_valid, par_stall;
	bcs_pkg::pow_t  par_item;
	logic           pow_valid, pow_stall;
	bcs_pkg::pow_t  pow_item;

	assign pidx = 3'(cfg_index - bcs_pkg::REG_POINT_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 1'b0;
			step_q   <= STEP_W'(bcs_pkg::STEP_RESET);
			for (int i = 0; i < NP; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcs_pkg::REG_DEGREE: degree_q <= cfg_data[0];
				bcs_pkg::REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				bcs_pkg::REG_POINT_0, bcs_pkg::REG_POINT_1, bcs_pkg::REG_POINT_2,
				bcs_pkg::REG_POINT_3, bcs_pkg::REG_POINT_4, bcs_pkg::REG_POINT_5: begin
					px_q[pidx] <= cfg_data[COORD_WIDTH-1:0];
					py_q[pidx] <= cfg_data[32+COORD_WIDTH-1:32];
				end
				default: ;
			endcase
		end
	end

	bcs_param #(
		.INDEX_WIDTH     (INDEX_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_param (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.step_size    (step_q),
		.out_valid    (par_valid),
		.out_stall    (par_stall),
		.out_item     (par_item)
	);

	bcs_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (par_valid),
		.in_stall  (par_stall),
		.in_item   (par_item),
		.out_valid (pow_valid),
		.out_stall (pow_stall),
		.out_item  (pow_item)
	);

	bcs_blend #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pow_valid),
		.in_stall  (pow_stall),
		.in_item   (pow_item),
		.quintic   (degree_q),
		.px        (px_q),
		.py        (py_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.past_end  (past_end)
	);

`ifndef NO_ASSERTIONS
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output stage is empty");
`endif

endmodule

@@ test/tb_bezier_curve_sampler.sv @@
// Testbench for bezier_curve_sampler: directed table, random phases, self-checking predictor.
`timescale 1ns / 100ps

module tb_bezier_curve_sampler;

	localparam int          HOLD_CYCLES  = 120;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          DRAIN_PAD    = 20;
	localparam int          PHASES       = 8;
	localparam int          PHASE_WORDS  = 225;
	localparam int          PLAN_ROWS    = 33;
	localparam int          PRINT_LIMIT  = 40;
	localparam longint unsigned T_ONE    = 64'd1 << 24;
	localparam longint      COORD_HI     = (64'sd1 <<< 31) - 1;
	localparam longint      COORD_LO     = -(64'sd1 <<< 31);
	localparam logic [31:0] C_MAX        = 32'h7FFF_FFFF;
	localparam logic [31:0] C_MIN        = 32'h8000_0000;
	localparam bcs_pkg::reg_idx_t REG_UNUSED = bcs_pkg::REG_POINT_5 + 4'd1;
	localparam bcs_pkg::reg_idx_t REG_LAST   = '1;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               past;
	} curve_pt_t;

	typedef struct packed {
		logic [15:0] index;
		logic        typed;
		curve_pt_t   want;
	} sample_t;

	typedef struct packed {
		row_kind_t          kind;
		bcs_pkg::reg_idx_t  idx;
		logic [63:0]        data;
		logic [15:0]        index;
		logic               typed;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               past;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        sample_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic               past_end;
	logic               cfg_we = 1'b0;
	bcs_pkg::reg_idx_t  cfg_index = bcs_pkg::REG_DEGREE;
	logic [63:0]        cfg_data = '0;

	logic               degree_cfg = 1'b0;
	logic [24:0]        step_cfg = 25'(bcs_pkg::STEP_RESET);
	logic [63:0]        pt_cfg [bcs_pkg::NPOINTS];
	int unsigned        pascal_row [2][6] = '{'{1, 3, 3, 1, 0, 0}, '{1, 5, 10, 10, 5, 1}};

	sample_t            index_feed [$];
	curve_pt_t          points_due [$];
	sample_t            offered;
	logic               in_fire = 1'b0;
	logic               steady = 1'b0;
	logic               hold_req = 1'b0;
	int                 hold_left = 0;
	int                 idle_cycles = 0;
	int                 mismatches = 0;

	row_t plan [PLAN_ROWS] = '{
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd0,     1'b1, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1000,  1'b1, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1001,  1'b1, 32'h0, 32'h0, 1'b1},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd65535, 1'b1, 32'h0, 32'h0, 1'b1},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_0, {C_MIN, C_MAX},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_1, {32'h0012_3456, 32'hFFED_CBA9},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_2, {32'h0000_0000, 32'hFFFF_FFFF},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_3, {32'hFFFF_0000, 32'h0001_0000},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_4, {32'h4000_0000, 32'hC000_0000},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_POINT_5, {C_MAX, C_MIN},
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_STEP,    64'h100_0000, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd0,     1'b1, C_MAX, C_MIN, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1,
		  1'b1, 32'h0001_0000, 32'hFFFF_0000, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd2,     1'b1, 32'h0, 32'h0, 1'b1},
		'{ROW_WRITE,  bcs_pkg::REG_STEP,    64'h80_0000, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd0,     1'b1, C_MAX, C_MIN, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_DEGREE,  64'd1, 16'd0,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd2,     1'b1, C_MIN, C_MAX, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd3,     1'b1, 32'h0, 32'h0, 1'b1},
		'{ROW_WRITE,  bcs_pkg::REG_STEP,    64'h200_0000, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd65535, 1'b1, C_MAX, C_MIN, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'h5AA5,  1'b1, C_MAX, C_MIN, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_DEGREE,  64'hFFFF_FFFF_FFFF_FFFE,
		  16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_STEP,    64'd1, 16'd0,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd65535, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'h8000,  1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  REG_UNUSED,           '1,    16'd0,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  REG_LAST,             '1,    16'd0,     1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_WRITE,  bcs_pkg::REG_STEP,    64'h100_0000, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd1,
		  1'b1, 32'h0001_0000, 32'hFFFF_0000, 1'b0},
		'{ROW_SAMPLE, bcs_pkg::REG_DEGREE,  64'd0, 16'd0,     1'b1, C_MAX, C_MIN, 1'b0}
	};

	bezier_curve_sampler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.past_end     (past_end),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned round_mul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic logic signed [31:0] clamp_coord(longint acc);
		longint r;
		r = (acc + (64'sd1 <<< 29)) >>> 30;
		if (r > COORD_HI)
			r = COORD_HI;
		if (r < COORD_LO)
			r = COORD_LO;
		return r[31:0];
	endfunction

	function automatic curve_pt_t eval_curve(logic [15:0] k);
		longint unsigned t, t30, u30;
		longint unsigned tpow [6];
		longint unsigned upow [6];
		longint          acc_x, acc_y, w;
		int              deg, i;
		curve_pt_t       pt;
		t = 64'(k) * 64'(step_cfg);
		pt = '0;
		if (t > T_ONE) begin
			pt.past = 1'b1;
			return pt;
		end
		t30 = t << 6;
		u30 = (64'd1 << 30) - t30;
		deg = degree_cfg ? 5 : 3;
		tpow[0] = 64'd1 << 30;
		upow[0] = 64'd1 << 30;
		for (i = 1; i <= deg; i++) begin
			tpow[i] = round_mul(tpow[i-1], t30);
			upow[i] = round_mul(upow[i-1], u30);
		end
		acc_x = 0;
		acc_y = 0;
		for (i = 0; i <= deg; i++) begin
			w = longint'(pascal_row[degree_cfg][i] * round_mul(tpow[i], upow[deg-i]));
			acc_x += w * longint'($signed(pt_cfg[i][31:0]));
			acc_y += w * longint'($signed(pt_cfg[i][63:32]));
		end
		pt.x = clamp_coord(acc_x);
		pt.y = clamp_coord(acc_y);
		return pt;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_reg(bcs_pkg::reg_idx_t idx, logic [63:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bcs_pkg::REG_DEGREE)
			degree_cfg = d[0];
		else if (idx == bcs_pkg::REG_STEP)
			step_cfg = d[24:0];
		else if (idx >= bcs_pkg::REG_POINT_0 && idx <= bcs_pkg::REG_POINT_5)
			pt_cfg[idx - bcs_pkg::REG_POINT_0] = d;
	endtask

	// wait until every word is taken and every curve point has come back
	task automatic settle();
		do
			@(posedge clk);
		while (index_feed.size() != 0 || in_valid || points_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (index_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
				offered = index_feed.pop_front();
				in_valid     <= 1'b1;
				sample_index <= offered.index;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(0, 99) < 23);
		end
	end

	always @(posedge clk) begin
		curve_pt_t want;
		in_fire <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			points_due.insert(points_due.size(),
			                  offered.typed ? offered.want : eval_curve(sample_index));
		if (out_valid && !out_stall) begin
			if (points_due.size() == 0) begin
				report_mismatch("curve point with none pending");
			end else begin
				want = points_due.pop_front();
				if (coord_x !== want.x)
					report_mismatch($sformatf("coord_x %h, want %h", coord_x, want.x));
				if (coord_y !== want.y)
					report_mismatch($sformatf("coord_y %h, want %h", coord_y, want.y));
				if (past_end !== want.past)
					report_mismatch($sformatf("past_end %b, want %b", past_end, want.past));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved in %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		sample_t         s;
		logic [63:0]     d;
		int unsigned     lim, roll;
		int              phase, i, small_val;
		logic            sat_hi, sat_lo;
		for (i = 0; i < bcs_pkg::NPOINTS; i++)
			pt_cfg[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				s.index = plan[r].index;
				s.typed = plan[r].typed;
				s.want  = '{plan[r].x, plan[r].y, plan[r].past};
				index_feed.insert(index_feed.size(), s);
			end
		end
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			d = {$urandom, $urandom};
			d[0] = phase[0];
			write_reg(bcs_pkg::REG_DEGREE, d);

			roll = $urandom_range(0, 2);
			if (phase == 0)
				d = 64'd1 << 24;
			else if (phase == 1)
				d = 64'd1;
			else if (phase == 5)
				d = 64'd0;
			else if (roll == 0)
				d = 64'($urandom_range(1, 1 << 24));
			else if (roll == 1)
				d = 64'($urandom_range(1, 4096));
			else
				d = 64'($urandom_range(1 << 16, 1 << 20));
			if ($urandom_range(0, 1))
				d[63:25] = 39'({$urandom, $urandom});
			write_reg(bcs_pkg::REG_STEP, d);

			// phases 3 and 6 put every point at an extreme to push the sum into saturation
			sat_hi = (phase == 3);
			sat_lo = (phase == 6);
			for (i = 0; i < bcs_pkg::NPOINTS; i++) begin
				roll = $urandom_range(0, 2);
				if (sat_hi)
					d = {C_MIN, C_MAX};
				else if (sat_lo)
					d = {C_MAX, C_MIN};
				else if (roll == 0)
					d = {$urandom, $urandom};
				else if (roll == 1)
					d = {$urandom_range(0, 1) ? C_MAX : C_MIN, $urandom_range(0, 1) ? C_MAX : C_MIN};
				else begin
					small_val = int'($urandom_range(0, 1 << 20)) - (1 << 19);
					d[31:0] = small_val;
					small_val = int'($urandom_range(0, 1 << 20)) - (1 << 19);
					d[63:32] = small_val;
				end
				write_reg(bcs_pkg::reg_idx_t'(bcs_pkg::REG_POINT_0 + i), d);
			end
			write_reg(bcs_pkg::reg_idx_t'(REG_UNUSED + $urandom_range(0, 7)),
			          {$urandom, $urandom});

			if (step_cfg == 0)
				lim = 65535;
			else
				lim = 32'(T_ONE / 64'(step_cfg));
			if (lim > 65535)
				lim = 65535;

			steady = (phase == 4);
			for (i = 0; i < PHASE_WORDS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					s.index = 16'($urandom_range(0, lim));
				else if (roll < 75)
					s.index = 16'(lim);
				else if (roll < 80)
					s.index = (lim < 65535) ? 16'(lim + 1) : 16'(lim);
				else
					s.index = 16'($urandom);
				s.typed = 1'b0;
				s.want  = '0;
				index_feed.insert(index_feed.size(), s);
			end
			if (phase == 2)
				hold_req = 1'b1;
			settle();
			steady = 1'b0;
		end

		repeat (DRAIN_PAD) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
